### rtl/core/hse_pkg.sv
// package for the heap sort engine: sizes, beat types and key helpers
// no dependencies; imported by every module of the engine except hse_ram
`default_nettype none

package hse_pkg;

  localparam int unsigned MAX_ITEMS   = 64;
  localparam int unsigned KEY_BITS    = 32;
  localparam int unsigned ADDR_W      = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W       = $clog2(MAX_ITEMS + 1);
  // child index 2*node+2 needs two more bits than a store address
  localparam int unsigned CHILD_W     = ADDR_W + 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [31:0] key;
    logic               last;
  } hse_item_t;

  typedef struct packed {
    logic signed [31:0] sorted_key;
    logic               final_res;
    logic               dropped;
  } hse_res_t;

  // classified beat passed from the front to the back
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [ADDR_W-1:0]   addr;
    logic                store;
    logic                last;
    logic [CNT_W-1:0]    n;
    logic                drop;
  } hse_cmd_t;

  function automatic logic [KEY_BITS-1:0] key_wrap(input logic signed [31:0] k);
    return KEY_BITS'(k);
  endfunction

  function automatic logic signed [31:0] key_out(input logic [KEY_BITS-1:0] k);
    return 32'(signed'(k));
  endfunction

  function automatic logic key_less(input logic [KEY_BITS-1:0] a,
                                    input logic [KEY_BITS-1:0] b);
    return signed'(a) < signed'(b);
  endfunction

endpackage

`default_nettype wire

### rtl/core/heap_sort_engine_unit.sv
// top level of the heap sort engine: front, beat queue and sorting back
// depends on hse_pkg, hse_front, hse_queue, hse_back (and hse_ram below it)
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------
//   keys in  | start & !busy       | item_i  (key, last)
//   sorted   | res_valid_o strobe  | res_o   (sorted_key, final_res, dropped)
//
// key beats are taken one per cycle while the two-entry queue has room;
// busy rises when the queue fills, which happens while the back sorts.
// in the back, each sift level is a read-compare-write on the dual-read
// store ram; the n sorted beats then follow on consecutive cycles,
// one strobe each. the receiver cannot stall; reset clears counts,
// queue and state machine.
`default_nettype none

module heap_sort_engine_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  wire hse_pkg::hse_item_t item_i,
  output logic                    busy,
  output logic                    res_valid_o,
  output hse_pkg::hse_res_t       res_o
);

  import hse_pkg::*;

  hse_cmd_t front_cmd, q_cmd;
  logic     accept, q_full, q_valid, q_pop;

  assign busy   = q_full;
  assign accept = start & ~q_full;

  hse_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .cmd_o    (front_cmd)
  );

  hse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .cmd_i   (front_cmd),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  hse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

### rtl/core/hse_ram.sv
// generic ram: one write port, two read ports with registered read data
// no dependencies
`default_nettype none

module hse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

### rtl/core/hse_front.sv
// front of the heap sort engine: takes key beats, assigns store slots,
// tracks the set count and overflow; depends on hse_pkg
`default_nettype none

module hse_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire hse_pkg::hse_item_t  item_i,
  output hse_pkg::hse_cmd_t        cmd_o
);

  import hse_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic             room;
  logic [CNT_W-1:0] cnt_inc;

  assign room    = cnt_q < CNT_W'(MAX_ITEMS);
  assign cnt_inc = room ? cnt_q + CNT_W'(1) : cnt_q;

  always_comb begin
    cmd_o.key   = key_wrap(item_i.key);
    cmd_o.addr  = cnt_q[ADDR_W-1:0];
    cmd_o.store = room;
    cmd_o.last  = item_i.last;
    cmd_o.n     = cnt_inc;
    cmd_o.drop  = ovf_q | ~room;
  end

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (accept_i) begin
      if (item_i.last) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end else begin
        cnt_d = cnt_inc;
        ovf_d = ovf_q | ~room;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/hse_queue.sv
// short fifo of classified beats between front and back
// depends on hse_pkg
`default_nettype none

module hse_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire hse_pkg::hse_cmd_t  cmd_i,
  input  wire logic               pop_i,
  output logic                    full_o,
  output logic                    valid_o,
  output hse_pkg::hse_cmd_t       cmd_o
);

  import hse_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  hse_cmd_t        slot_q [QUEUE_DEPTH];
  logic [PW-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CW'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = slot_q[rp_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wp_d = (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + PW'(1);
    end
    if (do_pop) begin
      rp_d = (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/hse_back.sv
// back of the heap sort engine: writes keys into the store, runs heapify
// and extraction with a hole-based sift-down, then streams the run out
// depends on hse_pkg and hse_ram
`default_nettype none

module hse_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  wire hse_pkg::hse_cmd_t  q_cmd_i,
  output logic                    q_pop_o,
  output logic                    res_valid_o,
  output hse_pkg::hse_res_t       res_o
);

  import hse_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BLD  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_EXT  = 3'd5;
  localparam logic [2:0] S_EXW  = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [ADDR_W-1:0]   node_q, node_d;
  logic [ADDR_W-1:0]   bi_q, bi_d;
  logic [ADDR_W-1:0]   e_q, e_d;
  logic [CNT_W-1:0]    sz_q, sz_d;
  logic [CNT_W-1:0]    n_q, n_d;
  logic                ext_q, ext_d;
  logic                drop_q, drop_d;
  logic [KEY_BITS-1:0] v_q, v_d;
  logic                ov_q, ov_d;
  logic                of_q, of_d;

  logic                we;
  logic [ADDR_W-1:0]   wa, ra, rb;
  logic [KEY_BITS-1:0] wd, rd_a, rd_b;

  logic [CHILD_W-1:0]  lc, rc, szx;
  logic                take_l, take_r, sift_end;
  logic [KEY_BITS-1:0] topv;
  logic [CNT_W-1:0]    half;

  assign lc   = {1'b0, node_q, 1'b1};
  assign rc   = {1'b0, node_q, 1'b0} + CHILD_W'(2);
  assign szx  = CHILD_W'(sz_q);
  assign half = q_cmd_i.n >> 1;

  // left child is in range whenever the compare state is reached
  assign take_l = key_less(v_q, rd_a);
  assign topv   = take_l ? rd_a : v_q;
  assign take_r = (rc < szx) && key_less(topv, rd_b);

  always_comb begin
    state_d  = state_q;
    node_d   = node_q;
    bi_d     = bi_q;
    e_d      = e_q;
    sz_d     = sz_q;
    n_d      = n_q;
    ext_d    = ext_q;
    drop_d   = drop_q;
    v_d      = v_q;
    ov_d     = 1'b0;
    of_d     = 1'b0;
    we       = 1'b0;
    wa       = node_q;
    wd       = v_q;
    ra       = node_q;
    rb       = rc[ADDR_W-1:0];
    q_pop_o  = 1'b0;
    sift_end = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_cmd_i.store) begin
            we = 1'b1;
            wa = q_cmd_i.addr;
            wd = q_cmd_i.key;
          end
          if (q_cmd_i.last) begin
            n_d    = q_cmd_i.n;
            sz_d   = q_cmd_i.n;
            drop_d = q_cmd_i.drop;
            ext_d  = 1'b0;
            if (q_cmd_i.n > CNT_W'(1)) begin
              bi_d    = ADDR_W'(half - CNT_W'(1));
              node_d  = ADDR_W'(half - CNT_W'(1));
              state_d = S_BLD;
            end else begin
              e_d     = '0;
              state_d = S_EMIT;
            end
          end
        end
      end
      S_BLD: begin
        ra      = node_q;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        v_d     = rd_a;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (lc >= szx) begin
          we       = 1'b1;
          wa       = node_q;
          wd       = v_q;
          sift_end = 1'b1;
        end else begin
          ra      = lc[ADDR_W-1:0];
          rb      = rc[ADDR_W-1:0];
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        we = 1'b1;
        wa = node_q;
        if (take_r) begin
          wd      = rd_b;
          node_d  = rc[ADDR_W-1:0];
          state_d = S_CHK;
        end else if (take_l) begin
          wd      = rd_a;
          node_d  = lc[ADDR_W-1:0];
          state_d = S_CHK;
        end else begin
          wd       = v_q;
          sift_end = 1'b1;
        end
      end
      S_EXT: begin
        ra      = '0;
        rb      = ADDR_W'(sz_q - CNT_W'(1));
        state_d = S_EXW;
      end
      S_EXW: begin
        // old root goes to the end, the end key sifts down from the root
        we      = 1'b1;
        wa      = ADDR_W'(sz_q - CNT_W'(1));
        wd      = rd_a;
        v_d     = rd_b;
        node_d  = '0;
        sz_d    = sz_q - CNT_W'(1);
        state_d = S_CHK;
      end
      S_EMIT: begin
        ra   = e_q;
        ov_d = 1'b1;
        of_d = (CNT_W'(e_q) + CNT_W'(1)) == n_q;
        e_d  = e_q + ADDR_W'(1);
        if ((CNT_W'(e_q) + CNT_W'(1)) == n_q) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (sift_end) begin
      if (!ext_q) begin
        if (bi_q != '0) begin
          bi_d    = bi_q - ADDR_W'(1);
          node_d  = bi_q - ADDR_W'(1);
          state_d = S_BLD;
        end else begin
          ext_d   = 1'b1;
          sz_d    = n_q;
          state_d = S_EXT;
        end
      end else if (sz_q > CNT_W'(1)) begin
        state_d = S_EXT;
      end else begin
        e_d     = '0;
        state_d = S_EMIT;
      end
    end
  end

  hse_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (wa),
    .wdata_i   (wd),
    .raddr_a_i (ra),
    .rdata_a_o (rd_a),
    .raddr_b_i (rb),
    .rdata_b_o (rd_b)
  );

  // read data of the emit cycle is already registered in the ram
  assign res_valid_o      = ov_q;
  assign res_o.sorted_key = key_out(rd_a);
  assign res_o.final_res  = of_q;
  assign res_o.dropped    = drop_q;

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    node_q <= node_d;
    bi_q   <= bi_d;
    e_q    <= e_d;
    sz_q   <= sz_d;
    n_q    <= n_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ext_q   <= 1'b0;
      drop_q  <= 1'b0;
      ov_q    <= 1'b0;
      of_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ext_q   <= ext_d;
      drop_q  <= drop_d;
      ov_q    <= ov_d;
      of_q    <= of_d;
    end
  end

endmodule

`default_nettype wire
